FILE: src/bsfr_pkg.sv
// ----------------------------------------------------------------------------
// bsfr_pkg
// Types, constants and the CRC-16/X.25 byte update for the frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  localparam int unsigned MAX_FRAME_LEN = 64;
  localparam int unsigned STORE_CAP     = MAX_FRAME_LEN - 2;
  localparam int unsigned STORE_AW      = (STORE_CAP > 1) ? $clog2(STORE_CAP) : 1;
  localparam int unsigned LEN_W         = 8;
  localparam int unsigned CNT_W         = $clog2(MAX_FRAME_LEN + 1);

  localparam int unsigned CFG_IDX_W     = 8;
  localparam int unsigned CFG_DATA_W    = 7;

  localparam logic [7:0]  HDR_BYTE      = 8'hF5;
  localparam logic [7:0]  ESC_BYTE      = 8'h55;
  localparam logic [15:0] CRC_POLY      = 16'h8408;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam int unsigned CHECK_SEL_BIT = 6;

  localparam logic [CFG_IDX_W-1:0]  REG_MIN_LEN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  REG_MAX_LEN   = CFG_IDX_W'(1);
  localparam logic [CFG_DATA_W-1:0] MIN_LEN_RESET = CFG_DATA_W'(2);
  localparam logic [CFG_DATA_W-1:0] MAX_LEN_RESET = CFG_DATA_W'(64);

  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_CTL,
    PH_LEN,
    PH_LOAD,
    PH_DRAIN
  } phase_e;

  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/bsfr_intf.sv
// ----------------------------------------------------------------------------
// bsfr interfaces
// Valid/ready channels: received bytes, payload bytes, register writes.
// ----------------------------------------------------------------------------
interface bsfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bsfr_pay_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last;
  modport source (output valid, output payload_byte, output last, input ready);
  modport sink   (input valid, input payload_byte, input last, output ready);
endinterface

interface bsfr_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bsfr_pkg::CFG_IDX_W-1:0]     index;
  logic [bsfr_pkg::CFG_DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/byte_stuffed_frame_receiver.sv
// ----------------------------------------------------------------------------
// byte_stuffed_frame_receiver
// Deframes F5 F5 / ctl / len / stuffed load, checks CRC-16/X.25 or XOR BCC,
// and plays the payload of a good frame out of the payload RAM.
// ----------------------------------------------------------------------------
//  channel  dir  beat                  accepted when
//  rx_i     in   rx_byte               valid && ready
//  pay_o    out  payload_byte, last    valid && ready
//  cfg_i    in   index, data           valid && ready (always ready)
//
// One raw byte per cycle while parsing; rx_i.ready is high in every phase but
// read-out. After a good frame the RAM is read one entry a cycle while pay_o does
// not stall, through a registered read port into the output register, and
// rx_i is held off until the last byte sits in the output register.
// Reset is asynchronous; no RAM clearing is needed.
// ----------------------------------------------------------------------------
module byte_stuffed_frame_receiver (
  input  logic           clk_i,
  input  logic           rst_ni,
  bsfr_rx_if.sink        rx_i,
  bsfr_pay_if.source     pay_o,
  bsfr_cfg_if.sink       cfg_i
);

  bsfr_pkg::phase_e phase_q, phase_d;

  logic [bsfr_pkg::CFG_DATA_W-1:0] min_q, max_q;
  logic [bsfr_pkg::LEN_W-1:0]      len_q, len_d;
  logic [7:0]                      ctl_q, ctl_d;
  logic [bsfr_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                            esc_q, esc_d;
  logic [15:0]                     crc_q, crc_d;
  logic [7:0]                      bcc_q, bcc_d;
  logic [15:0]                     crc_at_q, crc_at_d;
  logic [7:0]                      bcc_at_q, bcc_at_d;
  logic [15:0]                     chk_q, chk_d;

  logic [bsfr_pkg::CNT_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic                            pend_q, pend_d;
  logic                            pend_last_q;
  logic [7:0]                      rdata_q;
  logic                            out_valid_q, out_valid_d;
  logic [7:0]                      out_byte_q;
  logic                            out_last_q;

  logic [7:0] mem [bsfr_pkg::STORE_CAP];

  logic                        fire;
  logic [7:0]                  b;
  logic [15:0]                 crc_fed;
  logic [7:0]                  bcc_fed;
  logic                        len_ok;
  logic                        take_en;
  logic [7:0]                  take_val;
  logic [bsfr_pkg::LEN_W-1:0]  plen;
  logic [bsfr_pkg::LEN_W:0]    cnt_inc;
  logic                        in_load_part;
  logic [15:0]                 chk_new;
  logic                        check_ok;
  logic                        frame_end;
  logic                        frame_good;
  logic                        bad_esc;
  logic                        mem_we;
  logic                        out_free;
  logic                        pop;
  logic                        issue;

  // ---------------------------------------------------------------- parse
  always_comb begin
    b            = rx_i.rx_byte;
    fire         = rx_i.valid && rx_i.ready;
    crc_fed      = bsfr_pkg::crc_feed((phase_q == bsfr_pkg::PH_HEAD1) ? bsfr_pkg::CRC_INIT
                                                                       : crc_q, b);
    bcc_fed      = ((phase_q == bsfr_pkg::PH_HEAD1) ? 8'h00 : bcc_q) ^ b;
    len_ok       = (b >= {1'b0, min_q}) && (b <= {1'b0, max_q}) && (b >= 8'd2) &&
                   (b <= bsfr_pkg::LEN_W'(bsfr_pkg::MAX_FRAME_LEN));
    bad_esc      = fire && (phase_q == bsfr_pkg::PH_LOAD) && esc_q && (b != bsfr_pkg::ESC_BYTE);
    take_en      = fire && (phase_q == bsfr_pkg::PH_LOAD) &&
                   (esc_q ? (b == bsfr_pkg::ESC_BYTE) : (b != bsfr_pkg::HDR_BYTE));
    take_val     = esc_q ? bsfr_pkg::HDR_BYTE : b;
    plen         = len_q - bsfr_pkg::LEN_W'(2);
    cnt_inc      = (bsfr_pkg::LEN_W + 1)'(cnt_q) + (bsfr_pkg::LEN_W + 1)'(1);
    in_load_part = bsfr_pkg::LEN_W'(cnt_q) < plen;
    chk_new      = in_load_part ? chk_q : {chk_q[7:0], take_val};
    check_ok     = ctl_q[bsfr_pkg::CHECK_SEL_BIT] ? (chk_new[15:8] == bcc_at_q)
                                                  : (chk_new == ~crc_at_q);
    frame_end    = take_en && (cnt_inc == {1'b0, len_q});
    frame_good   = frame_end && check_ok && (plen != '0);
    mem_we       = take_en && in_load_part &&
                   (bsfr_pkg::LEN_W'(cnt_q) < bsfr_pkg::LEN_W'(bsfr_pkg::STORE_CAP));
  end

  always_comb begin
    len_d    = len_q;
    ctl_d    = ctl_q;
    cnt_d    = cnt_q;
    esc_d    = esc_q;
    crc_d    = crc_q;
    bcc_d    = bcc_q;
    crc_at_d = crc_at_q;
    bcc_at_d = bcc_at_q;
    chk_d    = chk_q;
    if (fire) begin
      case (phase_q)
        bsfr_pkg::PH_HEAD1: begin
          if (b == bsfr_pkg::HDR_BYTE) begin
            crc_d = crc_fed;
            bcc_d = bcc_fed;
            chk_d = '0;
            cnt_d = '0;
            esc_d = 1'b0;
          end
        end
        bsfr_pkg::PH_HEAD2: begin
          if (b == bsfr_pkg::HDR_BYTE) begin
            crc_d = crc_fed;
            bcc_d = bcc_fed;
          end else begin
            cnt_d = '0;
            esc_d = 1'b0;
          end
        end
        bsfr_pkg::PH_CTL: begin
          ctl_d = b;
          crc_d = crc_fed;
          bcc_d = bcc_fed;
        end
        bsfr_pkg::PH_LEN: begin
          cnt_d = '0;
          esc_d = 1'b0;
          if (len_ok) begin
            len_d = b;
            crc_d = crc_fed;
            bcc_d = bcc_fed;
            if (b == 8'd2) begin
              crc_at_d = crc_fed;
              bcc_at_d = bcc_fed;
            end
          end
        end
        bsfr_pkg::PH_LOAD: begin
          crc_d = crc_fed;
          bcc_d = bcc_fed;
          if (bad_esc) begin
            cnt_d = '0;
            esc_d = 1'b0;
          end else if (take_en) begin
            esc_d = 1'b0;
            chk_d = chk_new;
            if (frame_end) begin
              cnt_d = '0;
            end else begin
              cnt_d = bsfr_pkg::CNT_W'(cnt_inc);
              if ((cnt_inc + (bsfr_pkg::LEN_W + 1)'(2)) == {1'b0, len_q}) begin
                crc_at_d = crc_fed;
                bcc_at_d = bcc_fed;
              end
            end
          end else begin
            esc_d = 1'b1;
          end
        end
        bsfr_pkg::PH_DRAIN: begin
        end
        default: begin
          cnt_d = '0;
          esc_d = 1'b0;
        end
      endcase
    end
  end

  // ----------------------------------------------------------- next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      bsfr_pkg::PH_HEAD1: begin
        if (fire && (b == bsfr_pkg::HDR_BYTE)) phase_d = bsfr_pkg::PH_HEAD2;
      end
      bsfr_pkg::PH_HEAD2: begin
        if (fire) phase_d = (b == bsfr_pkg::HDR_BYTE) ? bsfr_pkg::PH_CTL : bsfr_pkg::PH_HEAD1;
      end
      bsfr_pkg::PH_CTL: begin
        if (fire) phase_d = bsfr_pkg::PH_LEN;
      end
      bsfr_pkg::PH_LEN: begin
        if (fire) phase_d = len_ok ? bsfr_pkg::PH_LOAD : bsfr_pkg::PH_HEAD1;
      end
      bsfr_pkg::PH_LOAD: begin
        if (bad_esc) begin
          phase_d = bsfr_pkg::PH_HEAD1;
        end else if (frame_end) begin
          phase_d = frame_good ? bsfr_pkg::PH_DRAIN : bsfr_pkg::PH_HEAD1;
        end
      end
      bsfr_pkg::PH_DRAIN: begin
        if (pop && pend_last_q) phase_d = bsfr_pkg::PH_HEAD1;
      end
      default: phase_d = bsfr_pkg::PH_HEAD1;
    endcase
  end

  // ------------------------------------------------------------- read-out
  always_comb begin
    out_free    = !out_valid_q || pay_o.ready;
    pop         = pend_q && out_free;
    issue       = (phase_q == bsfr_pkg::PH_DRAIN) &&
                  (bsfr_pkg::LEN_W'(rd_ptr_q) < plen) && (!pend_q || pop);
    rd_ptr_d    = rd_ptr_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    if (frame_good) begin
      rd_ptr_d = '0;
    end else if (issue) begin
      rd_ptr_d = rd_ptr_q + bsfr_pkg::CNT_W'(1);
    end
    if (issue) begin
      pend_d = 1'b1;
    end else if (pop) begin
      pend_d = 1'b0;
    end
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (pay_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign rx_i.ready         = (phase_q != bsfr_pkg::PH_DRAIN);
  assign cfg_i.ready        = 1'b1;
  assign pay_o.valid        = out_valid_q;
  assign pay_o.payload_byte = out_byte_q;
  assign pay_o.last         = out_last_q;

  // ------------------------------------------------------------ registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= bsfr_pkg::PH_HEAD1;
      min_q       <= bsfr_pkg::MIN_LEN_RESET;
      max_q       <= bsfr_pkg::MAX_LEN_RESET;
      len_q       <= '0;
      ctl_q       <= '0;
      cnt_q       <= '0;
      esc_q       <= 1'b0;
      crc_q       <= bsfr_pkg::CRC_INIT;
      bcc_q       <= '0;
      crc_at_q    <= bsfr_pkg::CRC_INIT;
      bcc_at_q    <= '0;
      chk_q       <= '0;
      rd_ptr_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_q       <= len_d;
      ctl_q       <= ctl_d;
      cnt_q       <= cnt_d;
      esc_q       <= esc_d;
      crc_q       <= crc_d;
      bcc_q       <= bcc_d;
      crc_at_q    <= crc_at_d;
      bcc_at_q    <= bcc_at_d;
      chk_q       <= chk_d;
      rd_ptr_q    <= rd_ptr_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          bsfr_pkg::REG_MIN_LEN: min_q <= cfg_i.data;
          bsfr_pkg::REG_MAX_LEN: max_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  // payload RAM, one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[cnt_q[bsfr_pkg::STORE_AW-1:0]] <= take_val;
    end
    if (issue) begin
      rdata_q     <= mem[rd_ptr_q[bsfr_pkg::STORE_AW-1:0]];
      pend_last_q <= (bsfr_pkg::LEN_W'(rd_ptr_q) == (plen - bsfr_pkg::LEN_W'(1)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_byte_q <= rdata_q;
      out_last_q <= pend_last_q;
    end
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-stuffed frame receiver. Raw link bytes are
// queued as frames (CRC and BCC checks, stuffed loads, broken and noisy
// sequences) and fed with random gaps; the payload sink stalls at random.
// A deframer model computes the expected payload beats on every accepted
// byte, and each received beat is compared with the oldest expected one.
// Length limits are rewritten between phases while the receiver is idle.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned RAND_ITEMS   = 130;
  localparam int unsigned RND_MIN_LEN  = 3;
  localparam int unsigned RND_MAX_LEN  = 14;

  localparam logic [bsfr_pkg::CFG_IDX_W-1:0] REG_PAST_END = bsfr_pkg::REG_MAX_LEN + 1'b1;
  localparam logic [bsfr_pkg::CFG_IDX_W-1:0] REG_ALL_ONES = '1;

  typedef enum {FL_NONE, FL_CHECK, FL_ESCAPE, FL_HEADER} flaw_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pay_beat_t;

  logic clk_i;
  logic rst_ni;

  bsfr_rx_if  rx_if ();
  bsfr_pay_if pay_if ();
  bsfr_cfg_if cfg_if ();

  byte_stuffed_frame_receiver i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .pay_o  (pay_if),
    .cfg_i  (cfg_if)
  );

  // deframer model state
  bsfr_pkg::phase_e dfr_phase;
  logic [7:0]  dfr_len;
  logic [7:0]  dfr_ctl;
  int          dfr_count;
  logic        dfr_esc;
  logic [15:0] dfr_crc;
  logic [7:0]  dfr_bcc;
  logic [15:0] dfr_crc_snap;
  logic [7:0]  dfr_bcc_snap;
  logic [15:0] dfr_chk;
  logic [7:0]  dfr_store [bsfr_pkg::STORE_CAP];
  logic [6:0]  dfr_min_len;
  logic [6:0]  dfr_max_len;

  pay_beat_t   pay_expect [$];
  logic [7:0]  rx_pending [$];

  int unsigned rx_issued;
  int unsigned rx_beats;
  int unsigned rx_gap;
  logic        rx_burst;
  int unsigned pay_beats;
  int unsigned pay_seen;
  int unsigned pay_hold;
  logic        pay_burst;
  int unsigned err_count;
  int unsigned cycle_count;

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] x25_crc_next(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ b[i]) ? ((r >> 1) ^ bsfr_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void dfr_feed_checks(logic [7:0] b);
    dfr_crc = x25_crc_next(dfr_crc, b);
    dfr_bcc = dfr_bcc ^ b;
  endfunction

  function automatic void dfr_hunt();
    dfr_phase = bsfr_pkg::PH_HEAD1;
    dfr_count = 0;
    dfr_esc   = 1'b0;
  endfunction

  function automatic void dfr_snap();
    if (!dfr_esc && dfr_count + 2 == int'(dfr_len)) begin
      dfr_crc_snap = dfr_crc;
      dfr_bcc_snap = dfr_bcc;
    end
  endfunction

  function automatic void dfr_take(logic [7:0] v);
    int   plen;
    logic good;
    plen = int'(dfr_len) - 2;
    if (dfr_count < plen) begin
      dfr_store[dfr_count] = v;
    end else begin
      dfr_chk = {dfr_chk[7:0], v};
    end
    dfr_count++;
    dfr_snap();
    if (dfr_count < int'(dfr_len)) return;
    good = dfr_ctl[bsfr_pkg::CHECK_SEL_BIT] ? (dfr_chk[15:8] == dfr_bcc_snap)
                                            : (dfr_chk == ~dfr_crc_snap);
    dfr_hunt();
    if (good) begin
      for (int i = 0; i < plen; i++) begin
        pay_expect.push_back(pay_beat_t'{data: dfr_store[i], last: (i == plen - 1)});
      end
    end
  endfunction

  function automatic void dfr_step(logic [7:0] b);
    case (dfr_phase)
      bsfr_pkg::PH_HEAD1: begin
        if (b == bsfr_pkg::HDR_BYTE) begin
          dfr_crc   = bsfr_pkg::CRC_INIT;
          dfr_bcc   = '0;
          dfr_chk   = '0;
          dfr_count = 0;
          dfr_esc   = 1'b0;
          dfr_feed_checks(b);
          dfr_phase = bsfr_pkg::PH_HEAD2;
        end
      end
      bsfr_pkg::PH_HEAD2: begin
        if (b == bsfr_pkg::HDR_BYTE) begin
          dfr_feed_checks(b);
          dfr_phase = bsfr_pkg::PH_CTL;
        end else begin
          dfr_hunt();
        end
      end
      bsfr_pkg::PH_CTL: begin
        dfr_ctl = b;
        dfr_feed_checks(b);
        dfr_phase = bsfr_pkg::PH_LEN;
      end
      bsfr_pkg::PH_LEN: begin
        if (int'(b) < int'(dfr_min_len) || int'(b) > int'(dfr_max_len) ||
            b < 2 || int'(b) > bsfr_pkg::MAX_FRAME_LEN) begin
          dfr_hunt();
        end else begin
          dfr_len = b;
          dfr_feed_checks(b);
          dfr_count = 0;
          dfr_esc   = 1'b0;
          dfr_phase = bsfr_pkg::PH_LOAD;
          dfr_snap();
        end
      end
      bsfr_pkg::PH_LOAD: begin
        dfr_feed_checks(b);
        if (dfr_esc) begin
          if (b != bsfr_pkg::ESC_BYTE) begin
            dfr_hunt();
          end else begin
            dfr_esc = 1'b0;
            dfr_take(bsfr_pkg::HDR_BYTE);
          end
        end else if (b == bsfr_pkg::HDR_BYTE) begin
          dfr_esc = 1'b1;
        end else begin
          dfr_take(b);
        end
      end
      default: begin
        dfr_hunt();
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // beat checker and byte predictor
  always @(posedge clk_i) begin : beat_check
    pay_beat_t want;
    if (rst_ni && pay_if.valid && pay_if.ready) begin
      pay_beats <= pay_beats + 1;
      if (pay_expect.size() == 0) begin
        flag_mismatch($sformatf("payload beat %02h last %0b with none expected",
                                pay_if.payload_byte, pay_if.last));
      end else begin
        want = pay_expect.pop_front();
        if (pay_if.payload_byte !== want.data) begin
          flag_mismatch($sformatf("payload_byte %02h, expected %02h",
                                  pay_if.payload_byte, want.data));
        end
        if (pay_if.last !== want.last) begin
          flag_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                  pay_if.last, want.last, want.data));
        end
      end
    end
    if (rst_ni && rx_if.valid && rx_if.ready) begin
      rx_beats <= rx_beats + 1;
      dfr_step(rx_if.rx_byte);
    end
  end

  always @(negedge clk_i) begin : byte_feed
    if (!rx_if.valid || rx_beats == rx_issued) begin
      if (rx_gap != 0) begin
        rx_if.valid <= 1'b0;
        rx_gap = rx_gap - 1;
      end else if (rx_pending.size() != 0) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= rx_pending.pop_front();
        rx_issued = rx_issued + 1;
        if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
        rx_gap = rx_burst ? 0 : $urandom_range(0, 19);
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : pay_sink
    int unsigned hold;
    if (pay_seen != pay_beats) begin
      pay_seen = pay_beats;
      if ($urandom_range(0, 15) == 0) pay_burst = !pay_burst;
      hold = pay_burst ? 0 : $urandom_range(0, 19);
    end else begin
      hold = pay_hold;
    end
    pay_if.ready <= (hold == 0);
    pay_hold = (hold != 0) ? hold - 1 : 0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic wait_quiet();
    do begin
      @(negedge clk_i);
    end while (rx_pending.size() != 0 || rx_issued != rx_beats || pay_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // bring the receiver back to header hunt; F5 00 never completes a frame
  task automatic settle();
    wait_quiet();
    while (dfr_phase != bsfr_pkg::PH_HEAD1) begin
      rx_pending.push_back(bsfr_pkg::HDR_BYTE);
      rx_pending.push_back(8'h00);
      wait_quiet();
    end
  endtask

  task automatic write_reg(input logic [bsfr_pkg::CFG_IDX_W-1:0] idx, input logic [6:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do begin
      @(posedge clk_i);
    end while (!cfg_if.ready);
    case (idx)
      bsfr_pkg::REG_MIN_LEN: dfr_min_len = val;
      bsfr_pkg::REG_MAX_LEN: dfr_max_len = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_load_byte();
    case ($urandom_range(0, 7))
      0, 1: return bsfr_pkg::HDR_BYTE;
      2: return 8'h00;
      3: return 8'hFF;
      4: return bsfr_pkg::ESC_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_bad_length(input logic [7:0] len_b);
    rx_pending.push_back(bsfr_pkg::HDR_BYTE);
    rx_pending.push_back(bsfr_pkg::HDR_BYTE);
    rx_pending.push_back(8'($urandom));
    rx_pending.push_back(len_b);
  endtask

  task automatic queue_frame(input logic [7:0] ctl_b, input int unsigned npay,
                             input flaw_e flaw);
    logic [7:0]  raw [$];
    logic [7:0]  v;
    logic [7:0]  c_hi;
    logic [7:0]  c_lo;
    logic [15:0] crc;
    logic [7:0]  bcc;
    int unsigned bad_at;
    v = 8'($urandom);
    if (v == bsfr_pkg::HDR_BYTE) v = ~v;
    raw.push_back(bsfr_pkg::HDR_BYTE);
    raw.push_back((flaw == FL_HEADER) ? v : bsfr_pkg::HDR_BYTE);
    raw.push_back(ctl_b);
    raw.push_back(8'(npay + 2));
    bad_at = $urandom_range(0, npay);
    v = 8'($urandom);
    if (v == bsfr_pkg::ESC_BYTE) v = ~v;
    for (int i = 0; i < npay; i++) begin
      if (flaw == FL_ESCAPE && i == bad_at) begin
        raw.push_back(bsfr_pkg::HDR_BYTE);
        raw.push_back(v);
      end
      raw.push_back(pick_load_byte());
      if (raw[$] == bsfr_pkg::HDR_BYTE) raw.push_back(bsfr_pkg::ESC_BYTE);
    end
    if (flaw == FL_ESCAPE && bad_at >= npay) begin
      raw.push_back(bsfr_pkg::HDR_BYTE);
      raw.push_back(v);
    end
    crc = bsfr_pkg::CRC_INIT;
    bcc = '0;
    foreach (raw[i]) begin
      crc = x25_crc_next(crc, raw[i]);
      bcc = bcc ^ raw[i];
    end
    if (ctl_b[bsfr_pkg::CHECK_SEL_BIT]) begin
      c_hi = bcc;
      c_lo = pick_load_byte();
      if (flaw == FL_CHECK) c_hi = c_hi ^ 8'(1 << $urandom_range(0, 7));
    end else begin
      {c_hi, c_lo} = ~crc;
      if (flaw == FL_CHECK) {c_hi, c_lo} = {c_hi, c_lo} ^ 16'(1 << $urandom_range(0, 15));
    end
    raw.push_back(c_hi);
    if (c_hi == bsfr_pkg::HDR_BYTE) raw.push_back(bsfr_pkg::ESC_BYTE);
    raw.push_back(c_lo);
    if (c_lo == bsfr_pkg::HDR_BYTE) raw.push_back(bsfr_pkg::ESC_BYTE);
    foreach (raw[i]) rx_pending.push_back(raw[i]);
  endtask

  initial begin : stimulus
    int unsigned rand_bytes;
    int unsigned npay;
    int unsigned mark;
    flaw_e       fl;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    pay_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    rx_issued     = 0;
    rx_beats      = 0;
    rx_gap        = 0;
    rx_burst      = 1'b0;
    pay_beats     = 0;
    pay_seen      = 0;
    pay_hold      = 0;
    pay_burst     = 1'b0;
    err_count     = 0;
    cycle_count   = 0;
    dfr_phase     = bsfr_pkg::PH_HEAD1;
    dfr_len       = '0;
    dfr_ctl       = '0;
    dfr_count     = 0;
    dfr_esc       = 1'b0;
    dfr_crc       = bsfr_pkg::CRC_INIT;
    dfr_bcc       = '0;
    dfr_crc_snap  = bsfr_pkg::CRC_INIT;
    dfr_bcc_snap  = '0;
    dfr_chk       = '0;
    dfr_min_len   = bsfr_pkg::MIN_LEN_RESET;
    dfr_max_len   = bsfr_pkg::MAX_LEN_RESET;
    rand_bytes    = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset limits: idle noise, broken headers, both checks, drops
    rx_pending.push_back(8'h00);
    rx_pending.push_back(8'hFF);
    rx_pending.push_back(bsfr_pkg::HDR_BYTE);
    rx_pending.push_back(8'h00);
    queue_frame(8'h00, 3, FL_NONE);
    queue_frame(8'h40, 2, FL_NONE);
    queue_frame(8'hFF, 1, FL_NONE);
    queue_frame(8'hBF, 1, FL_NONE);
    queue_frame(8'h00, 0, FL_NONE);
    queue_frame(8'h40, 0, FL_NONE);
    queue_frame(8'h00, 2, FL_CHECK);
    queue_frame(8'h40, 2, FL_CHECK);
    queue_frame(8'h00, 2, FL_ESCAPE);
    queue_frame(8'h00, 2, FL_HEADER);
    queue_bad_length(8'h00);
    queue_bad_length(8'h01);
    queue_bad_length(8'(bsfr_pkg::MAX_FRAME_LEN + 1));
    queue_bad_length(8'hFF);
    queue_frame(8'h00, 4, FL_NONE);
    settle();

    // widest register values; hard length bounds still apply
    write_reg(bsfr_pkg::REG_MIN_LEN, 7'd0);
    write_reg(bsfr_pkg::REG_MAX_LEN, 7'd127);
    queue_bad_length(8'h00);
    queue_bad_length(8'h01);
    queue_bad_length(8'(bsfr_pkg::MAX_FRAME_LEN + 1));
    queue_frame(8'h40, 0, FL_NONE);
    queue_frame(8'h00, 1, FL_NONE);
    settle();

    // largest frame only
    write_reg(bsfr_pkg::REG_MIN_LEN, 7'(bsfr_pkg::MAX_FRAME_LEN));
    write_reg(bsfr_pkg::REG_MAX_LEN, 7'(bsfr_pkg::MAX_FRAME_LEN));
    queue_frame(8'h00, bsfr_pkg::MAX_FRAME_LEN - 2, FL_NONE);
    queue_frame(8'h00, 3, FL_NONE);
    queue_frame(8'h40, bsfr_pkg::MAX_FRAME_LEN - 2, FL_NONE);
    settle();

    // min above max: nothing passes
    write_reg(bsfr_pkg::REG_MIN_LEN, 7'd10);
    write_reg(bsfr_pkg::REG_MAX_LEN, 7'd5);
    queue_frame(8'h00, 8, FL_NONE);
    queue_frame(8'h40, 3, FL_NONE);
    settle();

    // single accepted length
    write_reg(bsfr_pkg::REG_MIN_LEN, 7'd5);
    queue_frame(8'h00, 3, FL_NONE);
    queue_frame(8'h00, 4, FL_NONE);
    queue_frame(8'h40, 2, FL_NONE);
    queue_frame(8'h40, 3, FL_NONE);
    settle();

    // random traffic; unmapped writes must leave the limits alone
    write_reg(bsfr_pkg::REG_MIN_LEN, 7'(RND_MIN_LEN));
    write_reg(bsfr_pkg::REG_MAX_LEN, 7'(RND_MAX_LEN));
    write_reg(REG_PAST_END, 7'd0);
    write_reg(REG_ALL_ONES, 7'd127);
    while (rand_bytes < RAND_ITEMS) begin
      mark = rx_pending.size();
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4)) rx_pending.push_back(8'($urandom));
        end
        1: begin
          if ($urandom_range(0, 1)) begin
            rx_pending.push_back(bsfr_pkg::HDR_BYTE);
            rx_pending.push_back(8'($urandom));
          end else begin
            queue_bad_length(8'($urandom_range(RND_MAX_LEN + 1, 255)));
          end
        end
        default: begin
          npay = $urandom_range(0, RND_MAX_LEN);
          case ($urandom_range(0, 7))
            0: fl = FL_CHECK;
            1: fl = FL_ESCAPE;
            2: fl = FL_HEADER;
            default: fl = FL_NONE;
          endcase
          queue_frame(8'($urandom), npay, fl);
        end
      endcase
      rand_bytes += rx_pending.size() - mark;
    end
    settle();

    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
